@@ hdl/signed_int_to_decimal_ascii_assert.svh @@
// assertion macros for the signed integer to decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define SIDA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SIDA_ASSERT_SAME(label, clk, rst, ante, cons)
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/sida_pkg.sv @@
// shared constants and types for the signed integer to decimal text converter
package sida_pkg;
   localparam int VALUE_BITS = 32;
   // decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int DIGIT_IDX_BITS = $clog2(DIGITS);
   localparam int SHIFT_CNT_BITS = $clog2(VALUE_BITS);
   localparam int CHAR_BITS = 6;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 6'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

   typedef logic [3:0] bcd_digit_type;
   typedef bcd_digit_type [DIGITS-1:0] bcd_word_type;
endpackage

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Converts one signed integer per transaction into its decimal ASCII text, one character per
// result transaction, most significant first, with a leading '-' for negative values and
// rsp_last_char set on the final digit; zero gives a single '0'. The magnitude runs through a
// bit-serial shift-and-add-three converter, one input bit per cycle, and the characters (1 to 11)
// then go out one by one while the output is not stalled. A new transaction is taken as soon as
// the last character sits in the output register.
module signed_int_to_decimal_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sida_pkg::VALUE_BITS-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sida_pkg::CHAR_BITS-1:0]        rsp_text_char,
   output logic                                  rsp_last_char
);
   import sida_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_EMIT
   } state_type;

   state_type                 state_ff;
   logic                      sign_pend_ff;
   logic [DIGIT_IDX_BITS-1:0] idx_ff;
   logic                      rsp_valid_ff;
   logic [CHAR_BITS-1:0]      rsp_char_ff;
   logic                      rsp_last_ff;

   logic [VALUE_BITS-1:0]     req_bits;
   logic [VALUE_BITS-1:0]     magnitude;
   logic                      conv_start;
   logic                      conv_done;
   bcd_word_type              digits;
   logic [DIGIT_IDX_BITS-1:0] lead;
   logic                      out_free;

   assign req_bits   = req_value;
   // the most negative value negates to itself, which read unsigned is the right magnitude
   assign magnitude  = req_bits[VALUE_BITS-1] ? (~req_bits + 1'b1) : req_bits;
   assign conv_start = (state_ff == S_IDLE) && req_valid;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   sida_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .magnitude (magnitude),
      .done      (conv_done),
      .digits    (digits)
   );

   // highest nonzero digit, zero stays at the units digit
   always_comb begin
      lead = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (digits[i] != 4'd0) begin
            lead = DIGIT_IDX_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  sign_pend_ff <= req_bits[VALUE_BITS-1];
                  state_ff     <= S_CONV;
               end
            end
            S_CONV: begin
               if (conv_done) begin
                  idx_ff   <= lead;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (sign_pend_ff) begin
                     sign_pend_ff <= 1'b0;
                     rsp_char_ff  <= CHAR_MINUS;
                     rsp_last_ff  <= 1'b0;
                  end else begin
                     rsp_char_ff <= CHAR_ZERO + {2'b00, digits[idx_ff]};
                     rsp_last_ff <= (idx_ff == '0);
                     if (idx_ff == '0) begin
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff <= idx_ff - 1'b1;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

`include "signed_int_to_decimal_ascii_assert.svh"

   `SIDA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `SIDA_ASSERT_SAME(a_sign_ok, clock, reset, rsp_valid && rsp_last_char, rsp_char_ff != CHAR_MINUS)
   `SIDA_ASSERT_SAME(a_done_in_conv, clock, reset, conv_done, state_ff == S_CONV)
endmodule

@@ hdl/sida_bcd.sv @@
// bit-serial binary to packed bcd converter (shift and add three)
module sida_bcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sida_pkg::VALUE_BITS-1:0] magnitude,
   output logic                           done,
   output sida_pkg::bcd_word_type         digits
);
   import sida_pkg::*;

   logic [VALUE_BITS-1:0]     mag_ff;
   bcd_word_type              bcd_ff;
   bcd_word_type              adj;
   bcd_word_type              bcd_in;
   logic [SHIFT_CNT_BITS-1:0] count_ff;
   logic                      busy_ff;
   logic                      done_ff;

   // every digit of five or more gets three added before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i] inside {[4'd5:4'd15]}) begin
            adj[i] = bcd_ff[i] + 4'd3;
         end else begin
            adj[i] = bcd_ff[i];
         end
      end
      for (int i = 0; i < DIGITS; i++) begin
         if (i == 0) begin
            bcd_in[i] = {adj[i][2:0], mag_ff[VALUE_BITS-1]};
         end else begin
            bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            mag_ff   <= magnitude;
            bcd_ff   <= '0;
            count_ff <= SHIFT_CNT_BITS'(VALUE_BITS - 1);
         end else if (busy_ff) begin
            bcd_ff   <= bcd_in;
            mag_ff   <= {mag_ff[VALUE_BITS-2:0], 1'b0};
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign digits = bcd_ff;
endmodule
